// ----- rtl/char_lcd_shadow_updater_assert.svh -----
// Assertion macros for the character LCD shadow updater.
`ifndef CHAR_LCD_SHADOW_UPDATER_ASSERT_SVH
`define CHAR_LCD_SHADOW_UPDATER_ASSERT_SVH
`ifndef SYNTHESIS
`define CLSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CLSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CLSU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CLSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/clsu_pkg.sv -----
// Types and constants for the character LCD shadow updater.
`default_nettype none
package clsu_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_CHAR = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_BACKLIGHT  = 2'd2,
      CMD_INIT       = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] col;
      logic [1:0] row;
      logic [7:0] ch;
      logic       backlight_on;
   } req_type;

   typedef struct packed {
      logic [6:0] target_address;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   localparam logic [1:0] CSR_COLS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_ADDR = 2'd2;

   localparam logic [4:0] COLS_RESET = 5'd16;
   localparam logic [2:0] ROWS_RESET = 3'd2;
   localparam logic [6:0] ADDR_RESET = 7'd39;

   localparam int SEQ_NIBBLES = 12;
   localparam int NIB_QW      = 4 * SEQ_NIBBLES;

   localparam logic [NIB_QW-1:0]      INIT_SEQ   = 48'h3332_280C_0106;
   localparam logic [SEQ_NIBBLES-1:0] WRITE_RS   = 12'h300;
   localparam logic [7:0]             CLEAR_BYTE = 8'h01;
   localparam logic [7:0]             SPACE_CHAR = 8'h20;
   localparam logic [7:0]             DDRAM_CMD  = 8'h80;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         2'd3:    base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/char_lcd_shadow_updater.sv -----
// Top level of the character LCD shadow updater: command sequencer and shadow memory.
//
//   channel  ports                            direction  contents
//   req      req_valid/req_ready/req_data     in         one command transaction
//   rsp      rsp_valid/rsp_ready/rsp_data     out        one expander byte per transaction
//   csr      csr_we/csr_index/csr_wdata       in         geometry and bus address writes
//
// One byte per cycle leaves the nibble shift queue while rsp_ready is high.
// Write char: shadow read and compare, then 12 bytes; a dropped write emits no bytes.
// Clear emits 6 bytes, set backlight 1, initialise 37.
// Reset is synchronous; the shadow reads as spaces through per-entry valid bits.
// A stalled rsp holds the output register and the queue; req_ready is low until the run ends.
`default_nettype none
`include "char_lcd_shadow_updater_assert.svh"
module char_lcd_shadow_updater
   import clsu_pkg::*;
#(
   parameter int MAX_COLS = 20,
   parameter int MAX_ROWS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);

   localparam int Depth = MAX_ROWS * MAX_COLS;
   localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [4:0]              cols_ff;
   logic [2:0]              rows_ff;
   logic [6:0]              addr_ff;
   logic                    bl_ff, bl_in;
   logic                    init_ff, init_in;
   logic [Depth-1:0]        vld_ff, vld_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [7:0]              ch_ff, ch_in;
   logic [7:0]              cmd_addr_ff, cmd_addr_in;
   logic [7:0]              rd_data_ff;
   logic                    hit_vld_ff;
   logic [NIB_QW-1:0]       nib_q_ff, nib_q_in;
   logic [SEQ_NIBBLES-1:0]  rs_q_ff, rs_q_in;
   logic [3:0]              nib_left_ff, nib_left_in;
   logic [1:0]              phase_ff, phase_in;
   logic                    lone_ff, lone_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [7:0]              shadow_mem [Depth];

   logic                    req_accept;
   logic                    in_range;
   logic [IdxW-1:0]         req_idx;
   logic                    mem_we;
   logic                    out_free;
   logic [7:0]              shadow_ch;
   logic [7:0]              nib_byte;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign in_range = ({1'b0, req_data.row} < rows_ff) && (req_data.col < cols_ff)
                     && (int'(req_data.row) < MAX_ROWS) && (int'(req_data.col) < MAX_COLS);
   assign req_idx  = IdxW'(int'(req_data.row) * MAX_COLS + int'(req_data.col));

   assign shadow_ch = hit_vld_ff ? rd_data_ff : SPACE_CHAR;
   assign nib_byte  = {nib_q_ff[NIB_QW-1 -: 4], bl_ff, (phase_ff == 2'd1), 1'b0,
                       rs_q_ff[SEQ_NIBBLES-1]};

   always_comb begin
      state_in     = state_ff;
      bl_in        = bl_ff;
      init_in      = init_ff;
      vld_in       = vld_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      cmd_addr_in  = cmd_addr_ff;
      nib_q_in     = nib_q_ff;
      rs_q_in      = rs_q_ff;
      nib_left_in  = nib_left_ff;
      phase_in     = phase_ff;
      lone_in      = lone_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               phase_in = 2'd0;
               case (req_data.cmd)
                  CMD_WRITE_CHAR: begin
                     if (in_range) begin
                        idx_in      = req_idx;
                        ch_in       = req_data.ch;
                        cmd_addr_in = DDRAM_CMD | (8'(req_data.col) + row_base(req_data.row));
                        state_in    = ST_CMP;
                     end
                  end
                  CMD_CLEAR: begin
                     nib_q_in    = {CLEAR_BYTE, {(NIB_QW-8){1'b0}}};
                     rs_q_in     = '0;
                     nib_left_in = 4'd2;
                     lone_in     = 1'b0;
                     if (init_ff) begin
                        vld_in = '0;
                     end
                     state_in    = ST_EMIT;
                  end
                  CMD_BACKLIGHT: begin
                     bl_in       = req_data.backlight_on;
                     nib_left_in = 4'd0;
                     lone_in     = 1'b1;
                     state_in    = ST_EMIT;
                  end
                  CMD_INIT: begin
                     nib_q_in    = INIT_SEQ;
                     rs_q_in     = '0;
                     nib_left_in = 4'(SEQ_NIBBLES);
                     lone_in     = 1'b1;
                     vld_in      = '0;
                     init_in     = 1'b1;
                     state_in    = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CMP: begin
            if (shadow_ch == ch_ff) begin
               state_in = ST_IDLE;
            end else begin
               mem_we         = 1'b1;
               vld_in[idx_ff] = 1'b1;
               nib_q_in       = {cmd_addr_ff, ch_ff, {(NIB_QW-16){1'b0}}};
               rs_q_in        = WRITE_RS;
               nib_left_in    = 4'd4;
               lone_in        = 1'b0;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.target_address = addr_ff;
               if (lone_ff) begin
                  rsp_data_in.bus_byte = {4'd0, bl_ff, 3'd0};
                  rsp_data_in.last     = (nib_left_ff == 4'd0);
                  lone_in              = 1'b0;
                  if (nib_left_ff == 4'd0) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_data_in.bus_byte = nib_byte;
                  rsp_data_in.last     = (nib_left_ff == 4'd1) && (phase_ff == 2'd2);
                  if (phase_ff == 2'd2) begin
                     phase_in    = 2'd0;
                     nib_q_in    = {nib_q_ff[NIB_QW-5:0], 4'd0};
                     rs_q_in     = {rs_q_ff[SEQ_NIBBLES-2:0], 1'b0};
                     nib_left_in = nib_left_ff - 4'd1;
                     if (nib_left_ff == 4'd1) begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     phase_in = phase_ff + 2'd1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bl_ff        <= 1'b0;
         init_ff      <= 1'b0;
         vld_ff       <= '0;
         nib_left_ff  <= 4'd0;
         phase_ff     <= 2'd0;
         lone_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bl_ff        <= bl_in;
         init_ff      <= init_in;
         vld_ff       <= vld_in;
         nib_left_ff  <= nib_left_in;
         phase_ff     <= phase_in;
         lone_ff      <= lone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ch_ff       <= ch_in;
      cmd_addr_ff <= cmd_addr_in;
      nib_q_ff    <= nib_q_in;
      rs_q_ff     <= rs_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         addr_ff <= ADDR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata[4:0];
            CSR_ROWS: rows_ff <= csr_wdata[2:0];
            CSR_ADDR: addr_ff <= csr_wdata;
            default:  cols_ff <= cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[idx_ff] <= ch_ff;
      end
      if (req_accept && in_range) begin
         rd_data_ff <= shadow_mem[req_idx];
         hit_vld_ff <= vld_ff[req_idx];
      end
   end

   `CLSU_ASSERT_IMPLY(a_emit_has_work, clock, reset, state_ff == ST_EMIT, lone_ff || (nib_left_ff != 4'd0))
   `CLSU_ASSERT_NEXT(a_write_goes_through_compare, clock, reset, req_accept && (req_data.cmd == CMD_WRITE_CHAR), state_ff != ST_EMIT)
   `CLSU_ASSERT_IMPLY(a_queue_bounded, clock, reset, 1'b1, nib_left_ff <= 4'(SEQ_NIBBLES))

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the character LCD shadow updater: predicted expander byte runs.
`timescale 1ns / 100ps
module testbench;
   import clsu_pkg::*;

   localparam int MAX_COLS = 20;
   localparam int MAX_ROWS = 4;
   localparam logic [7:0] ENABLE_MASK = 8'h04;
   localparam logic [7:0] RS_MASK = 8'h01;
   localparam logic [7:0] LIGHT_MASK = 8'h08;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT = 2000;

   class lcd_byte_scoreboard;
      rsp_type pending_bytes[$];
      logic [7:0] shadow[MAX_ROWS*MAX_COLS];
      logic backlight;
      logic initialised;
      logic [4:0] cols;
      logic [2:0] rows;
      logic [6:0] addr;
      int errors;
      int commands;
      int bytes_checked;
      int writes_sent;
      int writes_dropped;

      function new();
         foreach (shadow[i]) shadow[i] = SPACE_CHAR;
         backlight = 1'b0;
         initialised = 1'b0;
         cols = COLS_RESET;
         rows = ROWS_RESET;
         addr = ADDR_RESET;
      endfunction

      function void write_register(logic [1:0] index, logic [6:0] value);
         case (index)
            CSR_COLS: cols = value[4:0];
            CSR_ROWS: rows = value[2:0];
            CSR_ADDR: addr = value;
            default: ;
         endcase
      endfunction

      function void push_byte(logic [7:0] value);
         rsp_type item;
         item.target_address = addr;
         item.bus_byte = value;
         item.last = 1'b0;
         pending_bytes.push_back(item);
      endfunction

      function void push_nibble(logic [7:0] hi, logic [7:0] rs);
         logic [7:0] d;
         d = (hi & 8'hF0) | rs | (backlight ? LIGHT_MASK : 8'h00);
         push_byte(d);
         push_byte(d | ENABLE_MASK);
         push_byte(d & ~ENABLE_MASK);
      endfunction

      function void push_value(logic [7:0] value, logic [7:0] rs);
         push_nibble(value & 8'hF0, rs);
         push_nibble({value[3:0], 4'h0}, rs);
      endfunction

      function void predict_command(req_type r);
         logic [7:0] offsets[4];
         logic [7:0] position;
         int prior_size;
         int idx;
         rsp_type tail;
         offsets = '{8'h00, 8'h40, 8'h14, 8'h54};
         prior_size = pending_bytes.size();
         commands++;
         case (r.cmd)
            CMD_WRITE_CHAR: begin
               idx = r.row * MAX_COLS + r.col;
               if (r.row >= rows || r.col >= cols || r.row >= MAX_ROWS || r.col >= MAX_COLS
                   || shadow[idx] == r.ch) begin
                  writes_dropped++;
               end else begin
                  writes_sent++;
                  shadow[idx] = r.ch;
                  position = {3'b000, r.col} + offsets[r.row];
                  push_value(DDRAM_CMD | position, 8'h00);
                  push_value(r.ch, RS_MASK);
               end
            end
            CMD_CLEAR: begin
               push_value(CLEAR_BYTE, 8'h00);
               if (initialised) foreach (shadow[i]) shadow[i] = SPACE_CHAR;
            end
            CMD_BACKLIGHT: begin
               backlight = r.backlight_on;
               push_byte(backlight ? LIGHT_MASK : 8'h00);
            end
            default: begin
               push_byte(backlight ? LIGHT_MASK : 8'h00);
               push_nibble(8'h30, 8'h00);
               push_nibble(8'h30, 8'h00);
               push_nibble(8'h30, 8'h00);
               push_nibble(8'h20, 8'h00);
               push_value(8'h28, 8'h00);
               push_value(8'h0C, 8'h00);
               push_value(8'h01, 8'h00);
               push_value(8'h06, 8'h00);
               foreach (shadow[i]) shadow[i] = SPACE_CHAR;
               initialised = 1'b1;
            end
         endcase
         if (pending_bytes.size() > prior_size) begin
            tail = pending_bytes.pop_back();
            tail.last = 1'b1;
            pending_bytes.push_back(tail);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 30) $display("MISMATCH: %s", msg);
      endtask

      task check_bus_byte(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h to address %02h", got.bus_byte,
                             got.target_address));
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (got.target_address !== want.target_address)
               report($sformatf("byte %0d: address %02h, want %02h", bytes_checked,
                                got.target_address, want.target_address));
            if (got.bus_byte !== want.bus_byte)
               report($sformatf("byte %0d: data %02h, want %02h", bytes_checked,
                                got.bus_byte, want.bus_byte));
            if (got.last !== want.last)
               report($sformatf("byte %0d: last %b, want %b", bytes_checked,
                                got.last, want.last));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_COLS;
   logic [6:0] csr_wdata = '0;

   lcd_byte_scoreboard sb = new();
   bit quiet_phase = 1'b0;
   int idle_cycles = 0;
   int settings_used = 1;

   char_lcd_shadow_updater #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.predict_command(req_data);
         if (rsp_valid && rsp_ready) sb.check_bus_byte(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic serve_responses();
      int stall;
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   endtask

   initial begin
      while (reset) @(posedge clock);
      serve_responses();
   end

   task automatic send_command(req_type r);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(logic [4:0] cols, logic [2:0] rows, logic [6:0] addr);
      wait_until_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= {2'b00, cols};
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= {4'b0000, rows};
      @(posedge clock);
      csr_index <= CSR_ADDR;
      csr_wdata <= addr;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic req_type make_request(cmd_type c, int col, int row, int ch, bit light);
      req_type r;
      r.cmd = c;
      r.col = 5'(col);
      r.row = 2'(row);
      r.ch = 8'(ch);
      r.backlight_on = light;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int pick;
      int lim_c;
      int lim_r;
      r.col = 5'($urandom_range(0, 31));
      r.row = 2'($urandom_range(0, 3));
      r.ch = 8'($urandom_range(0, 255));
      r.backlight_on = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         r.cmd = CMD_WRITE_CHAR;
         lim_c = (sb.cols > MAX_COLS) ? MAX_COLS : sb.cols;
         lim_r = (sb.rows > MAX_ROWS) ? MAX_ROWS : sb.rows;
         if (lim_c > 0 && lim_r > 0 && $urandom_range(0, 9) != 0) begin
            r.col = 5'($urandom_range(0, lim_c - 1));
            r.row = 2'($urandom_range(0, lim_r - 1));
         end
         case ($urandom_range(0, 3))
            0: r.ch = SPACE_CHAR;
            1: if (r.col < MAX_COLS) r.ch = sb.shadow[r.row * MAX_COLS + r.col];
            default: ;
         endcase
      end else if (pick < 78) begin
         r.cmd = CMD_CLEAR;
      end else if (pick < 88) begin
         r.cmd = CMD_BACKLIGHT;
      end else begin
         r.cmd = CMD_INIT;
      end
      return r;
   endfunction

   initial begin
      int cols;
      int rows;
      int addr;
      int count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_command(make_request(CMD_WRITE_CHAR, 0, 0, 8'h41, 1'b1));
      send_command(make_request(CMD_WRITE_CHAR, 0, 0, 8'h41, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 16, 0, 8'h42, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 0, 2, 8'h43, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 31, 3, 8'hFF, 1'b1));
      send_command(make_request(CMD_CLEAR, 0, 0, 8'h00, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 0, 0, 8'h41, 1'b0));
      send_command(make_request(CMD_BACKLIGHT, 0, 0, 8'h00, 1'b1));
      send_command(make_request(CMD_INIT, 31, 3, 8'hFF, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 0, 0, 8'h41, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 15, 1, 8'hFF, 1'b1));
      send_command(make_request(CMD_WRITE_CHAR, 5, 1, 8'h20, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 3, 0, 8'h00, 1'b0));
      send_command(make_request(CMD_CLEAR, 31, 3, 8'hFF, 1'b1));
      send_command(make_request(CMD_WRITE_CHAR, 15, 1, 8'hFF, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 0, 0, 8'h20, 1'b0));
      send_command(make_request(CMD_BACKLIGHT, 31, 3, 8'hFF, 1'b0));
      send_command(make_request(CMD_BACKLIGHT, 0, 0, 8'h00, 1'b0));
      send_command(make_request(CMD_WRITE_CHAR, 7, 1, 8'h5A, 1'b0));
      send_command(make_request(CMD_INIT, 0, 0, 8'h00, 1'b1));

      for (int p = 0; p < 8; p++) begin
         addr = $urandom_range(0, 127);
         case (p)
            0: begin cols = 20; rows = 4; addr = 127; count = 70; end
            1: begin cols = 1; rows = 1; addr = 0; count = 40; end
            2: begin cols = 31; rows = 7; count = 60; end
            3: begin cols = 0; rows = 3; count = 15; end
            4: begin cols = 20; rows = 0; count = 15; end
            default: begin
               cols = $urandom_range(1, 20);
               rows = $urandom_range(1, 4);
               count = 70;
            end
         endcase
         program_registers(5'(cols), 3'(rows), 7'(addr));
         quiet_phase = (p % 3 == 2);
         repeat (count) send_command(random_request());
      end
      quiet_phase = 1'b0;

      wait_until_idle();
      repeat (20) @(posedge clock);
      if (sb.pending_bytes.size() != 0)
         sb.report($sformatf("%0d expected bytes never arrived", sb.pending_bytes.size()));
      $display("Ran %0d commands over %0d register settings; checked %0d expander bytes.",
               sb.commands, settings_used, sb.bytes_checked);
      $display("Character writes: %0d sent, %0d suppressed by range or shadow match.",
               sb.writes_sent, sb.writes_dropped);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- char_lcd_shadow_updater.f -----
+incdir+rtl
rtl/clsu_pkg.sv
rtl/char_lcd_shadow_updater.sv
tb/testbench.sv
